[rtl/core/tlb_page_table_translator_core_macros.svh]
// Assertion macros used by the translator's checker file.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_CORE_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLBPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLBPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tlbpt_pkg.sv]
// Shared widths, outcome codes and status types of the address translator.
package tlbpt_pkg;

    localparam int ADDR_W      = 16;
    localparam int OUTCOME_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OUTCOME_W-1:0] OUT_TLB_HIT  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_PT_HIT   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_LOADED   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NO_FRAME = 2'd3;

    // Fill state of the queue between the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Status the back part reports to the front part.
    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

[rtl/core/tlbpt_if.sv]
// Valid/ready channel interfaces for requests and responses of the translator.
interface tlbpt_in_if;
    logic                          valid;
    logic                          ready;
    logic [tlbpt_pkg::ADDR_W-1:0]  virt_addr;

    modport source (output valid, output virt_addr, input ready);
    modport sink   (input valid, input virt_addr, output ready);
endinterface

interface tlbpt_out_if;
    logic                            valid;
    logic                            ready;
    logic [tlbpt_pkg::ADDR_W-1:0]    phys_addr;
    logic [tlbpt_pkg::OUTCOME_W-1:0] outcome;

    modport source (output valid, output phys_addr, output outcome, input ready);
    modport sink   (input valid, input phys_addr, input outcome, output ready);
endinterface

[rtl/core/tlb_page_table_translator_core.sv]
// Address translator top level: a four-entry TLB backed by a page table with frame allocation.
//
// Each request transfer carries a 16-bit logical address; the bits above OFFSET_BITS form
// the page number (reduced modulo PAGE_COUNT) and the low bits the offset. The block answers
// every request with exactly one response transfer, in order, carrying the physical address
// and an outcome: TLB hit, page table hit, page fault loaded (a fresh frame was handed out by
// the incrementing allocator), or no free frame (physical address zero, nothing updated).
// After a page table hit or a page fault the TLB entry at the round-robin fill pointer is
// replaced. After reset the page table valid bits are swept to zero, entry by entry; no
// request is taken during that sweep. The back part handles each item first in ST_IDLE,
// where it pops the item and reads the page table memory, whose read data is registered,
// and then in ST_RESOLVE, where it searches the TLB, resolves and updates; it pops no new
// item until the current one has resolved. A response that is held back lets the next
// item resolve in the cycle it is finally taken, so two response transfers may then
// follow in consecutive cycles. When PAGE_COUNT is a power of two the front part adds no
// delay; otherwise it reduces the page number by a reciprocal multiplication with a
// registered quotient and takes no new request until the previous one has been pushed
// into the queue. A two-entry queue between the parts and the response register let the
// front part take the next request while a response still waits to be taken.
module tlb_page_table_translator_core #(
    parameter int TLB_ENTRIES = 4,
    parameter int OFFSET_BITS = 12,
    parameter int PAGE_COUNT  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tlbpt_in_if.sink     i_req,
    tlbpt_out_if.source  o_rsp
);
    localparam int ADDR_W  = tlbpt_pkg::ADDR_W;
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int TLB_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FREE_W  = $clog2(PAGE_COUNT + 1);
    localparam int ITEM_W  = PAGE_W + ADDR_W;

    tlbpt_pkg::t_queue_status queue_status;
    tlbpt_pkg::t_back_status  back_status;

    logic                push;
    logic [PAGE_W-1:0]   push_page;
    logic [ADDR_W-1:0]   push_addr;
    logic                pop;
    logic [ITEM_W-1:0]   head;

    // The front part accepts requests and works out the page number.
    tlbpt_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .PAGE_COUNT  (PAGE_COUNT),
        .PAGE_W      (PAGE_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_back      (back_status),
        .i_queue     (queue_status),
        .o_push      (push),
        .o_push_page (push_page),
        .o_push_addr (push_addr)
    );

    // Classified items wait here until the back part is free.
    tlbpt_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_page, push_addr}),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (queue_status)
    );

    // The back part owns all translation state and the response register.
    tlbpt_back #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .OFFSET_BITS (OFFSET_BITS),
        .PAGE_COUNT  (PAGE_COUNT),
        .PAGE_W      (PAGE_W),
        .TLB_W       (TLB_W),
        .FREE_W      (FREE_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_queue     (queue_status),
        .i_head_page (head[ITEM_W-1:ADDR_W]),
        .i_head_addr (head[ADDR_W-1:0]),
        .o_pop       (pop),
        .o_status    (back_status),
        .o_rsp       (o_rsp)
    );

endmodule

[rtl/core/tlbpt_queue.sv]
// Short register queue that decouples the front and back parts.
module tlbpt_queue #(
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_push_data,
    input  logic                     i_pop,
    output logic [WIDTH-1:0]         o_head,
    output tlbpt_pkg::t_queue_status o_status
);
    localparam int DEPTH = tlbpt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

[rtl/core/tlbpt_front.sv]
// Front part: takes request transfers and derives the page number of each address.
module tlbpt_front #(
    parameter int OFFSET_BITS = 12,
    parameter int PAGE_COUNT  = 16,
    parameter int PAGE_W      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tlbpt_in_if.sink                      i_req,
    input  tlbpt_pkg::t_back_status       i_back,
    input  tlbpt_pkg::t_queue_status      i_queue,
    output logic                          o_push,
    output logic [PAGE_W-1:0]             o_push_page,
    output logic [tlbpt_pkg::ADDR_W-1:0]  o_push_addr
);
    localparam int ADDR_W = tlbpt_pkg::ADDR_W;

    if ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0) begin : g_mask
        // A power-of-two table size reduces the page number by keeping its low bits.
        logic [ADDR_W-1:0] raw_page;

        assign raw_page    = ADDR_W'(i_req.virt_addr >> OFFSET_BITS);
        assign i_req.ready = !i_queue.full && !i_back.clearing;
        assign o_push      = i_req.valid && i_req.ready;
        assign o_push_page = raw_page[PAGE_W-1:0];
        assign o_push_addr = i_req.virt_addr;
    end else begin : g_recip
        // Remainder by the table size through a reciprocal multiplication: the quotient
        // is registered first, then multiplied back and subtracted.
        localparam int RAW_W  = ADDR_W - OFFSET_BITS;
        localparam int SHIFT  = RAW_W + $clog2(PAGE_COUNT);
        localparam int RECIP  = ((1 << SHIFT) + PAGE_COUNT - 1) / PAGE_COUNT;
        localparam int PROD_W = RAW_W + SHIFT + 1;

        logic              r_busy;
        logic              r_phase;
        logic [ADDR_W-1:0] r_addr;
        logic [RAW_W-1:0]  r_quot;
        logic [RAW_W-1:0]  raw_page;
        logic [PROD_W-1:0] product;
        logic [RAW_W-1:0]  back_mul;
        logic [RAW_W-1:0]  rem;
        logic              accept;

        assign raw_page = r_addr[ADDR_W-1:OFFSET_BITS];
        assign product  = PROD_W'(raw_page) * PROD_W'(RECIP);
        assign back_mul = r_quot * RAW_W'(PAGE_COUNT);
        assign rem      = raw_page - back_mul;
        assign accept   = i_req.valid && i_req.ready;

        assign i_req.ready = !r_busy && !i_back.clearing;
        assign o_push      = r_busy && r_phase && !i_queue.full;
        assign o_push_page = PAGE_W'(rem);
        assign o_push_addr = r_addr;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy  <= 1'b0;
                r_phase <= 1'b0;
            end else if (accept) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (o_push) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_phase <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_addr <= i_req.virt_addr;
            end
            if (r_busy && !r_phase) begin
                r_quot <= product[SHIFT +: RAW_W];
            end
        end
    end

endmodule

[rtl/core/tlbpt_back.sv]
// Back part: TLB search, page table lookup, frame allocation and the result register.
module tlbpt_back #(
    parameter int TLB_ENTRIES = 4,
    parameter int OFFSET_BITS = 12,
    parameter int PAGE_COUNT  = 16,
    parameter int PAGE_W      = 4,
    parameter int TLB_W       = 2,
    parameter int FREE_W      = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlbpt_pkg::t_queue_status      i_queue,
    input  logic [PAGE_W-1:0]             i_head_page,
    input  logic [tlbpt_pkg::ADDR_W-1:0]  i_head_addr,
    output logic                          o_pop,
    output tlbpt_pkg::t_back_status       o_status,
    tlbpt_out_if.source                   o_rsp
);
    localparam int ADDR_W    = tlbpt_pkg::ADDR_W;
    localparam int OUTCOME_W = tlbpt_pkg::OUTCOME_W;
    localparam int FRAME_W   = PAGE_W;
    localparam int WIDE_W    = 32;

    localparam logic [1:0] ST_CLEAR   = 2'd0;
    localparam logic [1:0] ST_IDLE    = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]             r_state;
    logic [PAGE_W-1:0]      r_clr_idx;
    logic [PAGE_W-1:0]      r_page;
    logic [ADDR_W-1:0]      r_addr;
    logic [FRAME_W:0]       r_pt_rd;
    logic [FRAME_W:0]       r_pt [PAGE_COUNT];
    logic [PAGE_W-1:0]      r_tlb_tag   [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [TLB_W-1:0]       r_fill_ptr;
    logic [FREE_W-1:0]      r_free;
    logic                   r_out_valid;
    logic [ADDR_W-1:0]      r_phys;
    logic [OUTCOME_W-1:0]   r_outcome;

    logic                 resolve;
    logic                 tlb_hit;
    logic [FRAME_W-1:0]   tlb_frame;
    logic                 pt_valid;
    logic                 exhausted;
    logic [FRAME_W-1:0]   sel_frame;
    logic [OUTCOME_W-1:0] sel_outcome;
    logic                 do_fill;
    logic                 do_alloc;
    logic [ADDR_W-1:0]    offset;
    logic [ADDR_W-1:0]    n_phys;
    logic [TLB_W-1:0]     n_fill_ptr;

    assign o_pop     = (r_state == ST_IDLE) && !i_queue.empty;
    assign resolve   = (r_state == ST_RESOLVE) && (!r_out_valid || o_rsp.ready);
    assign pt_valid  = r_pt_rd[FRAME_W];
    assign exhausted = (r_free >= FREE_W'(PAGE_COUNT));

    // Highest index first so that the lowest matching entry wins.
    always_comb begin
        tlb_hit   = 1'b0;
        tlb_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_tag[i] == r_page)) begin
                tlb_hit   = 1'b1;
                tlb_frame = r_tlb_frame[i];
            end
        end
    end

    always_comb begin
        sel_frame   = tlb_frame;
        sel_outcome = tlbpt_pkg::OUT_TLB_HIT;
        do_fill     = 1'b0;
        do_alloc    = 1'b0;
        if (!tlb_hit) begin
            if (pt_valid) begin
                sel_frame   = r_pt_rd[FRAME_W-1:0];
                sel_outcome = tlbpt_pkg::OUT_PT_HIT;
                do_fill     = 1'b1;
            end else if (exhausted) begin
                sel_frame   = '0;
                sel_outcome = tlbpt_pkg::OUT_NO_FRAME;
            end else begin
                sel_frame   = r_free[FRAME_W-1:0];
                sel_outcome = tlbpt_pkg::OUT_LOADED;
                do_fill     = 1'b1;
                do_alloc    = 1'b1;
            end
        end
    end

    assign offset = r_addr & ADDR_W'((WIDE_W'(1) << OFFSET_BITS) - WIDE_W'(1));
    assign n_phys = (sel_outcome == tlbpt_pkg::OUT_NO_FRAME) ? '0
                  : ADDR_W'((WIDE_W'(sel_frame) << OFFSET_BITS) | WIDE_W'(offset));
    assign n_fill_ptr = (r_fill_ptr == TLB_W'(TLB_ENTRIES - 1)) ? '0
                      : r_fill_ptr + TLB_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_tlb_valid <= '0;
            r_fill_ptr  <= '0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + PAGE_W'(1);
                    if (r_clr_idx == PAGE_W'(PAGE_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE: begin
                    if (resolve) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_CLEAR;
            endcase

            if (resolve) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (resolve && do_fill) begin
                r_tlb_valid[r_fill_ptr] <= 1'b1;
                r_fill_ptr              <= n_fill_ptr;
            end
            if (resolve && do_alloc) begin
                r_free <= r_free + FREE_W'(1);
            end
        end
    end

    // Page table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_pt[r_clr_idx] <= '0;
        end else if (resolve && do_alloc) begin
            r_pt[r_page] <= {1'b1, r_free[FRAME_W-1:0]};
        end
        if (o_pop) begin
            r_pt_rd <= r_pt[i_head_page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_page <= i_head_page;
            r_addr <= i_head_addr;
        end
        if (resolve && do_fill) begin
            r_tlb_tag[r_fill_ptr]   <= r_page;
            r_tlb_frame[r_fill_ptr] <= sel_frame;
        end
        if (resolve) begin
            r_phys    <= n_phys;
            r_outcome <= sel_outcome;
        end
    end

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.phys_addr   = r_phys;
    assign o_rsp.outcome     = r_outcome;

endmodule

[rtl/core/tlbpt_checker.sv]
// Port-level assertions of the address translator and their bind to the top level.
`include "tlb_page_table_translator_core_macros.svh"

module tlbpt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [tlbpt_pkg::ADDR_W-1:0]    i_rsp_phys_addr,
    input logic [tlbpt_pkg::OUTCOME_W-1:0] i_rsp_outcome
);
    logic [7:0] r_pending;

    // Requests taken but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({i_req_valid && i_req_ready, i_rsp_valid && i_rsp_ready})
                2'b10:   r_pending <= r_pending + 8'd1;
                2'b01:   r_pending <= r_pending - 8'd1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    // Frames never run out: a frame is only handed to a page that has none.
    `TLBPT_ASSERT_SAME(a_no_exhaustion, i_clk, i_rst_n, i_rsp_valid,
        i_rsp_outcome != tlbpt_pkg::OUT_NO_FRAME, "frame allocator reported exhaustion")

    // A response is only offered for a request that has been taken.
    `TLBPT_ASSERT_SAME(a_rsp_has_req, i_clk, i_rst_n, i_rsp_valid,
        r_pending != 8'd0, "response without an outstanding request")

    // A stalled response holds its value.
    `TLBPT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_rsp_phys_addr) && $stable(i_rsp_outcome),
        "stalled response changed")

endmodule

bind tlb_page_table_translator_core tlbpt_checker u_tlbpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_phys_addr (o_rsp.phys_addr),
    .i_rsp_outcome   (o_rsp.outcome)
);
